// ===== rtl/arnorm_pkg.sv =====
package arnorm_pkg;

    // code points that are dropped or folded
    localparam logic [15:0] CP_DIACRITIC_LO = 16'h064B;
    localparam logic [15:0] CP_DIACRITIC_HI = 16'h065F;
    localparam logic [15:0] CP_SUPERSCRIPT_ALEF = 16'h0670;
    localparam logic [15:0] CP_TATWEEL = 16'h0640;
    localparam logic [15:0] CP_ALEF = 16'h0627;
    localparam logic [15:0] CP_ALEF_MADDA = 16'h0622;
    localparam logic [15:0] CP_ALEF_HAMZA_ABOVE = 16'h0623;
    localparam logic [15:0] CP_ALEF_HAMZA_BELOW = 16'h0625;
    localparam logic [15:0] CP_ALEF_WASLA = 16'h0671;
    localparam logic [15:0] CP_TEH_MARBUTA = 16'h0629;
    localparam logic [15:0] CP_HEH = 16'h0647;
    localparam logic [15:0] CP_ALEF_MAKSURA = 16'h0649;
    localparam logic [15:0] CP_YEH = 16'h064A;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] seq_len_t;
    typedef logic [1:0] pend_cnt_t;

    // sequence length announced by a lead byte, 0 for a byte that cannot lead
    function automatic seq_len_t lead_length(input byte_t b);
        seq_len_t len;
        len = 3'd0;
        if (b < 8'h80)
            len = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 3'd4;
        return len;
    endfunction

    // second byte range depends on the lead byte (table 3-7)
    function automatic logic second_ok(input byte_t lead, input byte_t b);
        byte_t lo;
        byte_t hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == 8'hE0)
            lo = 8'hA0;
        else if (lead == 8'hED)
            hi = 8'h9F;
        else if (lead == 8'hF0)
            lo = 8'h90;
        else if (lead == 8'hF4)
            hi = 8'h8F;
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic logic is_cont(input byte_t b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

// ===== rtl/arabic_utf8_token_normalizer_unit.sv =====
// arabic_utf8_token_normalizer_unit
//
// takes the utf-8 bytes of a token on the s_ stream (s_tdata = byte, s_tlast marks the
// token's final byte) and sends the normalized bytes on the m_ stream, one byte per
// request. arabic diacritics, superscript alef and tatweel are removed, alef variants
// fold to alef, teh marbuta to heh and alef maksura to yeh; anything else, including
// broken or truncated sequences, leaves as its original bytes.
// m_tlast marks the final request of a token; m_tuser[1] then says whether the token
// kept any bytes. a token that leaves nothing (or whose final byte leaves nothing)
// still gets one closing request with m_tuser[0] (has_byte) low.
// an accepted input byte goes through the input register, then the result register.
// throughput: one input byte per cycle while every byte yields at most one output
// request and m_tready stays high; a byte that releases several bytes (a folded letter,
// a flushed broken sequence, up to 4 bytes) holds the input until they have all left,
// since the result register drains one byte per cycle while m_tready is high.
// a stalled m_tready freezes the result register; the input register still takes one
// more byte, then s_tready drops until the result register frees up.
// reset clears the held sequence and both pipeline registers; nothing is in flight.
module arabic_utf8_token_normalizer_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  arnorm_pkg::byte_t      s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // in_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output arnorm_pkg::byte_t      m_tdata,   // [7:0] out_byte
    output logic                   m_tlast,   // out_last
    output logic [1:0]             m_tuser    // [0] has_byte, [1] keep_token
);
    import arnorm_pkg::*;

    // input register
    logic      a_valid_reg, a_valid_next;
    byte_t     a_byte_reg;
    logic      a_last_reg;

    // decoder state
    byte_t     pend_reg [3];
    byte_t     pend_next [3];
    pend_cnt_t pc_reg, pc_next;
    seq_len_t  el_reg, el_next;
    logic      emitted_reg, emitted_next;

    // result register: the bytes one input byte releases
    logic      b_valid_reg, b_valid_next;
    byte_t     b_bytes_reg [4];
    logic [1:0] b_pos_reg, b_pos_next;
    logic [1:0] b_last_idx_reg;
    logic      b_has_reg;
    logic      b_last_reg;
    logic      b_keep_reg;

    // decode of the byte in the input register
    seq_len_t  lead_len;
    logic      take;
    logic      fin;
    logic [15:0] cp;
    logic      two_byte;
    logic      drop_cp;
    logic      map_cp;
    logic [15:0] mapped_cp;
    logic      special;
    logic      emit_old;
    logic      emit_b;
    byte_t     emit_bytes [4];
    logic [2:0] emit_n;

    logic      s_accept;
    logic      at_end;
    logic      b_done;
    logic      b_free;
    logic      a_move;
    logic      b_load;

    assign s_accept = s_tvalid && s_tready;
    assign at_end   = b_pos_reg == b_last_idx_reg;
    assign b_done   = b_valid_reg && m_tready && at_end;
    assign b_free   = !b_valid_reg || b_done;
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;
    // a non-final byte that releases nothing leaves no request
    assign b_load   = a_move && ((emit_n != 3'd0) || a_last_reg);

    always_comb
    begin
        lead_len = lead_length(a_byte_reg);
        take = (pc_reg != 2'd0) &&
               ((pc_reg == 2'd1) ? second_ok(pend_reg[0], a_byte_reg) : is_cont(a_byte_reg));
        fin = take && (({1'b0, pc_reg} + 3'd1) >= el_reg);
        // only two-byte sequences can land in the arabic block
        cp = {5'd0, pend_reg[0][4:0], a_byte_reg[5:0]};
        two_byte = fin && (pc_reg == 2'd1);
        drop_cp = two_byte && (((cp >= CP_DIACRITIC_LO) && (cp <= CP_DIACRITIC_HI)) ||
                               (cp == CP_SUPERSCRIPT_ALEF) || (cp == CP_TATWEEL));
        map_cp = 1'b0;
        mapped_cp = CP_ALEF;
        if (two_byte)
        begin
            if ((cp == CP_ALEF_MADDA) || (cp == CP_ALEF_HAMZA_ABOVE) ||
                (cp == CP_ALEF_HAMZA_BELOW) || (cp == CP_ALEF_WASLA))
            begin
                map_cp = 1'b1;
                mapped_cp = CP_ALEF;
            end
            else if (cp == CP_TEH_MARBUTA)
            begin
                map_cp = 1'b1;
                mapped_cp = CP_HEH;
            end
            else if (cp == CP_ALEF_MAKSURA)
            begin
                map_cp = 1'b1;
                mapped_cp = CP_YEH;
            end
        end
        special = drop_cp || map_cp;
        // held bytes leave raw on a break, a plain finish or the token end
        emit_old = (pc_reg != 2'd0) && !special && (!take || fin || a_last_reg);
        emit_b = !special && (take ? (fin || a_last_reg)
                                   : ((lead_len <= 3'd1) || a_last_reg));

        for (int i = 0; i < 4; i++)
            emit_bytes[i] = 8'h00;
        emit_n = 3'd0;
        if (map_cp)
        begin
            emit_bytes[0] = {3'b110, mapped_cp[10:6]};
            emit_bytes[1] = {2'b10, mapped_cp[5:0]};
            emit_n = 3'd2;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (emit_old && (2'(i) < pc_reg))
                begin
                    emit_bytes[emit_n[1:0]] = pend_reg[i];
                    emit_n = emit_n + 3'd1;
                end
            end
            if (emit_b)
            begin
                emit_bytes[emit_n[1:0]] = a_byte_reg;
                emit_n = emit_n + 3'd1;
            end
        end
    end

    // decoder state update
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pend_next[i] = pend_reg[i];
        pc_next = pc_reg;
        el_next = el_reg;
        emitted_next = emitted_reg;
        if (a_move)
        begin
            pc_next = 2'd0;
            el_next = 3'd0;
            if (take && !fin && !a_last_reg)
            begin
                pend_next[pc_reg] = a_byte_reg;
                pc_next = pc_reg + 2'd1;
                el_next = el_reg;
            end
            else if (!take && (lead_len >= 3'd2) && !a_last_reg)
            begin
                pend_next[0] = a_byte_reg;
                pc_next = 2'd1;
                el_next = lead_len;
            end
            if (a_last_reg)
                emitted_next = 1'b0;
            else if (emit_n != 3'd0)
                emitted_next = 1'b1;
        end
    end

    // pipeline control
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (s_accept)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        b_pos_next = b_pos_reg;
        if (b_load)
        begin
            b_valid_next = 1'b1;
            b_pos_next = 2'd0;
        end
        else if (b_done)
        begin
            b_valid_next = 1'b0;
            b_pos_next = 2'd0;
        end
        else if (b_valid_reg && m_tready)
            b_pos_next = b_pos_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_pos_reg <= 2'd0;
            pc_reg <= 2'd0;
            el_reg <= 3'd0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_pos_reg <= b_pos_next;
            pc_reg <= pc_next;
            el_reg <= el_next;
            emitted_reg <= emitted_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_byte_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
        for (int i = 0; i < 3; i++)
            pend_reg[i] <= pend_next[i];
        if (b_load)
        begin
            for (int i = 0; i < 4; i++)
                b_bytes_reg[i] <= emit_bytes[i];
            b_last_idx_reg <= (emit_n == 3'd0) ? 2'd0 : 2'(emit_n - 3'd1);
            b_has_reg <= emit_n != 3'd0;
            b_last_reg <= a_last_reg;
            b_keep_reg <= (emit_n != 3'd0) || emitted_reg;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_bytes_reg[b_pos_reg];
    assign m_tlast  = b_last_reg && at_end;
    assign m_tuser  = {b_last_reg && at_end && b_keep_reg, b_has_reg};

    // read position never runs past the bytes loaded
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_pos_reg <= b_last_idx_reg))
        else $error("result read position past loaded bytes");

    // a byteless request only closes a token
    a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_has_reg) |-> (b_last_reg && (b_last_idx_reg == 2'd0)))
        else $error("byteless request that does not close a token");

    // a held prefix is always shorter than its announced length
    a_pending_short: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != 2'd0) |-> (el_reg > {1'b0, pc_reg}))
        else $error("held prefix reaches announced length");

    // input only backs up when both registers are full and the output cannot drain
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (a_valid_reg && b_valid_reg && !b_done))
        else $error("input stalled without a full pipeline");

    // the decoder state never moves while the input register waits
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> ($stable(pc_reg) && $stable(el_reg)))
        else $error("decoder state changed while stalled");

endmodule

// ===== verif/arabic_utf8_token_normalizer_unit_test.sv =====
`timescale 1ns / 1ps

module arabic_utf8_token_normalizer_unit_test;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int SHOWN_MAX    = 10;      // mismatches printed in full
    localparam int RANDOM_BYTES = 86;      // random bytes after the directed table
    localparam int DRAIN_CYCLES = 20;      // quiet time after the last expected request
    localparam int WAIT_MAX     = 17;      // longest idle draw on either side

    typedef arnorm_pkg::byte_t byte_t;

    // one output request as the block should present it
    typedef struct packed {
        byte_t data;
        logic  has_byte;
        logic  last;
        logic  keep;
    } norm_out_t;

    // one directed input byte, with a typed result where it is obvious
    typedef struct packed {
        byte_t     data;
        logic      last;
        logic      typed;
        norm_out_t want;
    } script_row_t;

    localparam norm_out_t NO_RESULT = '0;
    localparam int SCRIPT_LEN = 24;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // extremes of the byte, each a one-byte token
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
        // overlong lead, then a lone continuation closing the token
        '{8'hC0, 1'b0, 1'b1, '{8'hC0, 1'b1, 1'b0, 1'b0}},
        '{8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b1}},
        // token of just a tatweel: dropped entirely
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        // alef madda, fathatan, teh marbuta, alef maksura, alef wasla, tatweel
        '{8'hD8, 1'b0, 1'b0, NO_RESULT},
        '{8'hA2, 1'b0, 1'b0, NO_RESULT},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'h8B, 1'b0, 1'b0, NO_RESULT},
        '{8'hD8, 1'b0, 1'b0, NO_RESULT},
        '{8'hA9, 1'b0, 1'b0, NO_RESULT},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'h89, 1'b0, 1'b0, NO_RESULT},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        '{8'hB1, 1'b0, 1'b0, NO_RESULT},
        '{8'hD9, 1'b0, 1'b0, NO_RESULT},
        // trailing tatweel: closing request without a byte, token kept
        '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        // three held bytes broken by ascii: four requests from one byte
        '{8'hF0, 1'b0, 1'b0, NO_RESULT},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h41, 1'b1, 1'b0, NO_RESULT},
        // sequence cut off by the end of the token
        '{8'hE0, 1'b0, 1'b0, NO_RESULT},
        '{8'hA0, 1'b1, 1'b0, NO_RESULT}
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    byte_t      s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    byte_t      m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    // predictor state: held prefix of an unfinished sequence
    byte_t held_byte [3];
    int    held_cnt;
    int    want_len;
    logic  token_emitted;

    norm_out_t awaited_out [$];   // output requests still to come, oldest first
    int        mismatches;
    int        cycles;
    bit        in_calm;           // stretches where the sender never idles
    bit        out_calm;          // stretches where the receiver never stalls

    arabic_utf8_token_normalizer_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // bytes a lead announces, 0 for a byte that cannot start a sequence
    function automatic int starter_len(input byte_t b);
        if (b < 8'h80)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // narrowed second-byte ranges that exclude overlongs, surrogates and > U+10FFFF
    function automatic logic second_in_range(input byte_t lead, input byte_t b);
        byte_t lo;
        byte_t hi;
        lo = 8'h80;
        hi = 8'hBF;
        case (lead)
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
        endcase
        return (b >= lo) && (b <= hi);
    endfunction

    // queue tail appends
    function automatic void append_byte(ref byte_t q [$], input byte_t b);
        q.insert(q.size(), b);
    endfunction

    function automatic void append_out(ref norm_out_t q [$], input norm_out_t r);
        q.insert(q.size(), r);
    endfunction

    function automatic void add_byte(ref byte_t bytes [$], input byte_t b);
        if (bytes.size() < 4)
            append_byte(bytes, b);
    endfunction

    // a complete sequence: drop, fold or pass through its own bytes
    function automatic void close_sequence(input byte_t seq [4], input int len,
                                           ref byte_t bytes [$]);
        logic [20:0] cp;
        logic [15:0] folded;
        if (len == 2)
            cp = {10'd0, seq[0][4:0], seq[1][5:0]};
        else if (len == 3)
            cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
        else
            cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};

        if ((cp >= arnorm_pkg::CP_DIACRITIC_LO && cp <= arnorm_pkg::CP_DIACRITIC_HI)
            || cp == arnorm_pkg::CP_SUPERSCRIPT_ALEF || cp == arnorm_pkg::CP_TATWEEL)
            return;

        folded = 16'h0000;
        if (cp == arnorm_pkg::CP_ALEF_MADDA || cp == arnorm_pkg::CP_ALEF_HAMZA_ABOVE
            || cp == arnorm_pkg::CP_ALEF_HAMZA_BELOW || cp == arnorm_pkg::CP_ALEF_WASLA)
            folded = arnorm_pkg::CP_ALEF;
        else if (cp == arnorm_pkg::CP_TEH_MARBUTA)
            folded = arnorm_pkg::CP_HEH;
        else if (cp == arnorm_pkg::CP_ALEF_MAKSURA)
            folded = arnorm_pkg::CP_YEH;

        if (folded != 16'h0000)
        begin
            add_byte(bytes, {3'b110, folded[10:6]});
            add_byte(bytes, {2'b10, folded[5:0]});
        end
        else
        begin
            for (int i = 0; i < len; i++)
                add_byte(bytes, seq[i]);
        end
    endfunction

    // advance the predictor by one accepted byte, return the requests it causes
    function automatic void normalize_byte(input byte_t b, input logic last,
                                           ref norm_out_t outs [$]);
        byte_t     bytes [$];
        byte_t     seq [4];
        logic      taken;
        logic      fits;
        int        len;
        norm_out_t r;

        taken = 1'b0;
        outs.delete();

        if (held_cnt > 0)
        begin
            fits = (held_cnt == 1) ? second_in_range(held_byte[0], b) : (b[7:6] == 2'b10);
            if (fits)
            begin
                taken = 1'b1;
                if (held_cnt + 1 >= want_len || held_cnt >= 3)
                begin
                    for (int i = 0; i < held_cnt; i++)
                        seq[i] = held_byte[i];
                    seq[held_cnt] = b;
                    close_sequence(seq, held_cnt + 1, bytes);
                    held_cnt = 0;
                    want_len = 0;
                end
                else
                begin
                    held_byte[held_cnt] = b;
                    held_cnt++;
                end
            end
            else
            begin
                // broken prefix goes out raw, the new byte is decoded afresh
                for (int i = 0; i < held_cnt; i++)
                    add_byte(bytes, held_byte[i]);
                held_cnt = 0;
                want_len = 0;
            end
        end

        if (!taken)
        begin
            len = starter_len(b);
            if (len <= 1)
                add_byte(bytes, b);
            else
            begin
                held_byte[0] = b;
                held_cnt = 1;
                want_len = len;
            end
        end

        // token ends with a sequence still open
        if (last && held_cnt > 0)
        begin
            for (int i = 0; i < held_cnt; i++)
                add_byte(bytes, held_byte[i]);
            held_cnt = 0;
            want_len = 0;
        end

        if (bytes.size() > 0)
            token_emitted = 1'b1;

        foreach (bytes[i])
        begin
            r.data     = bytes[i];
            r.has_byte = 1'b1;
            r.last     = last && (i == bytes.size() - 1);
            r.keep     = r.last;
            append_out(outs, r);
        end

        if (last)
        begin
            if (bytes.size() == 0)
            begin
                r.data     = 8'h00;
                r.has_byte = 1'b0;
                r.last     = 1'b1;
                r.keep     = token_emitted;
                append_out(outs, r);
            end
            token_emitted = 1'b0;
        end
    endfunction

    // idle draw, with occasional switches into and out of a no-idle stretch
    function automatic int draw_wait(ref bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // random token: mostly well-formed characters with an arabic bias, some noise
    function automatic void build_token(ref byte_t tok [$]);
        int          chars;
        int          len;
        int          keep_n;
        logic [10:0] cp;
        byte_t       seq [4];

        chars = $urandom_range(1, 5);
        for (int c = 0; c < chars; c++)
        begin
            case ($urandom_range(0, 9))
                0:
                    append_byte(tok, byte_t'($urandom_range(0, 127)));
                1, 2, 3, 4:
                begin
                    case ($urandom_range(0, 13))
                        0:  cp = arnorm_pkg::CP_ALEF_MADDA[10:0];
                        1:  cp = arnorm_pkg::CP_ALEF_HAMZA_ABOVE[10:0];
                        2:  cp = arnorm_pkg::CP_ALEF_HAMZA_BELOW[10:0];
                        3:  cp = arnorm_pkg::CP_ALEF_WASLA[10:0];
                        4:  cp = arnorm_pkg::CP_TEH_MARBUTA[10:0];
                        5:  cp = arnorm_pkg::CP_ALEF_MAKSURA[10:0];
                        6:  cp = arnorm_pkg::CP_TATWEEL[10:0];
                        7:  cp = arnorm_pkg::CP_SUPERSCRIPT_ALEF[10:0];
                        8:  cp = arnorm_pkg::CP_ALEF[10:0];
                        9:  cp = arnorm_pkg::CP_DIACRITIC_LO[10:0];
                        10: cp = arnorm_pkg::CP_DIACRITIC_HI[10:0];
                        11: cp = 11'($urandom_range(16'h064B, 16'h065F));
                        default: cp = 11'($urandom_range(16'h0600, 16'h06FF));
                    endcase
                    append_byte(tok, {3'b110, cp[10:6]});
                    append_byte(tok, {2'b10, cp[5:0]});
                end
                5:
                begin
                    append_byte(tok, byte_t'($urandom_range(8'hC2, 8'hDF)));
                    append_byte(tok, byte_t'($urandom_range(8'h80, 8'hBF)));
                end
                6, 7, 9:
                begin
                    // valid 3- or 4-byte sequence; a broken pick keeps only a prefix
                    len = ($urandom_range(0, 1) == 0) ? 3 : 4;
                    seq[0] = (len == 3) ? byte_t'($urandom_range(8'hE0, 8'hEF))
                                        : byte_t'($urandom_range(8'hF0, 8'hF4));
                    do
                        seq[1] = byte_t'($urandom_range(8'h80, 8'hBF));
                    while (!second_in_range(seq[0], seq[1]));
                    seq[2] = byte_t'($urandom_range(8'h80, 8'hBF));
                    seq[3] = byte_t'($urandom_range(8'h80, 8'hBF));
                    keep_n = len;
                    if ($urandom_range(0, 2) == 0)
                        keep_n = $urandom_range(1, len - 1);
                    for (int i = 0; i < keep_n; i++)
                        append_byte(tok, seq[i]);
                end
                default:
                    append_byte(tok, byte_t'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // present one byte, wait for the handshake, then record what it should cause
    task automatic send_byte(input byte_t b, input logic last, input logic typed,
                             input norm_out_t want);
        int        gap;
        norm_out_t outs [$];
        gap = draw_wait(in_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        normalize_byte(b, last, outs);
        if (typed)
            append_out(awaited_out, want);
        else
        begin
            foreach (outs[i])
                append_out(awaited_out, outs[i]);
        end
    endtask

    // compare one accepted output request against the oldest expectation
    task automatic check_output(input norm_out_t got);
        norm_out_t exp_out;
        if (awaited_out.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $display("unexpected output request: data %h has_byte %b last %b keep %b",
                         got.data, got.has_byte, got.last, got.keep);
            return;
        end
        exp_out = awaited_out.pop_front();
        if (got != exp_out)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $display("mismatch (data has_byte last keep): expected %h %b %b %b, got %h %b %b %b",
                         exp_out.data, exp_out.has_byte, exp_out.last, exp_out.keep,
                         got.data, got.has_byte, got.last, got.keep);
        end
    endtask

    // receiver: random stalls per request, checking on each handshake
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_wait(out_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_output('{m_tdata, m_tuser[0], m_tlast, m_tuser[1]});
        end
    end

    // sender: directed table, then random tokens, then drain and verdict
    initial
    begin
        byte_t tok [$];
        int    sent;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        held_byte     = '{8'h00, 8'h00, 8'h00};
        held_cnt      = 0;
        want_len      = 0;
        token_emitted = 1'b0;
        in_calm       = 1'b0;
        sent          = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_byte(SCRIPT[i].data, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);

        while (sent < RANDOM_BYTES)
        begin
            tok.delete();
            build_token(tok);
            foreach (tok[i])
            begin
                send_byte(tok[i], i == tok.size() - 1, 1'b0, NO_RESULT);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (awaited_out.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_out.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
